// ===== rtl/core/dfpq_pkg.sv =====
// Shared types and codes for the drop-front packet queue.
package dfpq_pkg;

   // result kinds
   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_POPPED  = 2'd1;
   localparam logic [1:0] KIND_DROPPED = 2'd2;

   // commands
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // register index (paddr word bit)
   localparam logic CSR_CAPACITY = 1'b0;

   localparam int LEN_W    = 11;
   localparam int HANDLE_W = 16;
   localparam int LEN_MAX  = 2047;

   typedef struct packed {
      logic                cmd;
      logic [HANDLE_W-1:0] packet_handle;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] out_handle;
      logic [1:0]          out_kind;
      logic                became_nonempty;
      logic [LEN_W-1:0]    length;
      logic [31:0]         drop_total;
      logic [LEN_W-1:0]    highwater;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept_item;
      logic load_result;
   } ctl_cmd_type;

endpackage

// ===== rtl/core/dfpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dfpq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/dfpq_ctrl.sv =====
// Controller: accepts one beat, waits for the slot read, loads the result register.
module dfpq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dfpq_pkg::ctl_cmd_type ctl
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LOAD = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign ctl.accept_item = (state_ff == ST_IDLE) && req_valid;
   assign ctl.load_result = (state_ff == ST_LOAD) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.accept_item) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (ctl.load_result) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register occupancy
   always_comb begin
      if (ctl.load_result) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/dfpq_datapath.sv =====
// Datapath: ring pointers, counters, capacity register, slot RAM and result register.
module dfpq_datapath #(
   parameter int MAX_DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dfpq_pkg::ctl_cmd_type            ctl,
   input  dfpq_pkg::req_type                req_data,
   output dfpq_pkg::rsp_type                rsp_data,
   input  logic                             cfg_wr_en,
   input  logic [dfpq_pkg::LEN_W-1:0]       cfg_wdata,
   output logic [dfpq_pkg::LEN_W-1:0]       cfg_capacity
);

   localparam int AW      = $clog2(MAX_DEPTH);
   localparam int CAP_MAX = (MAX_DEPTH > dfpq_pkg::LEN_MAX) ? dfpq_pkg::LEN_MAX : MAX_DEPTH;
   localparam int CAP_RST = (MAX_DEPTH > 1024) ? 1024 : MAX_DEPTH;
   localparam int LW      = dfpq_pkg::LEN_W;

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [LW-1:0] occ_ff, occ_in;
   logic [LW-1:0] peak_ff, peak_in;
   logic [31:0]   drops_ff, drops_in;
   logic [LW-1:0] cap_ff, cap_in;
   logic [1:0]    kind_ff, kind_in;
   logic          woke_ff, woke_in;
   dfpq_pkg::rsp_type rsp_ff;

   logic                          is_push, is_drop, is_pop, take;
   logic [dfpq_pkg::HANDLE_W-1:0] slot_rd;

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
      if (idx == AW'(MAX_DEPTH - 1)) begin
         return '0;
      end
      return idx + 1'b1;
   endfunction

   assign is_push = (req_data.cmd == dfpq_pkg::CMD_PUSH);
   assign is_drop = is_push && (occ_ff >= cap_ff);
   assign is_pop  = !is_push && (occ_ff != '0);
   assign take    = is_drop || is_pop;

   // item update, evaluated on the accepted beat
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      occ_in   = occ_ff;
      peak_in  = peak_ff;
      drops_in = drops_ff;
      kind_in  = kind_ff;
      woke_in  = woke_ff;
      if (ctl.accept_item) begin
         if (take) head_in = ring_next(head_ff);
         if (is_push) tail_in = ring_next(tail_ff);
         // drop plus push leaves the length unchanged
         occ_in = occ_ff - LW'(take) + LW'(is_push);
         if (occ_in > peak_ff) peak_in = occ_in;
         if (is_drop && (drops_ff != '1)) drops_in = drops_ff + 32'd1;
         if (is_drop) begin
            kind_in = dfpq_pkg::KIND_DROPPED;
         end else if (is_pop) begin
            kind_in = dfpq_pkg::KIND_POPPED;
         end else begin
            kind_in = dfpq_pkg::KIND_NONE;
         end
         woke_in = is_push && (occ_in == LW'(1));
      end
   end

   // capacity write: zero means one, above the ring size saturates; held while not empty
   always_comb begin
      cap_in = cap_ff;
      if (cfg_wr_en && (occ_ff == '0)) begin
         if (cfg_wdata == '0) begin
            cap_in = LW'(1);
         end else if (cfg_wdata > LW'(CAP_MAX)) begin
            cap_in = LW'(CAP_MAX);
         end else begin
            cap_in = cfg_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         occ_ff   <= '0;
         peak_ff  <= '0;
         drops_ff <= '0;
         cap_ff   <= LW'(CAP_RST);
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         occ_ff   <= occ_in;
         peak_ff  <= peak_in;
         drops_ff <= drops_in;
         cap_ff   <= cap_in;
      end
   end

   // per-item payload, no reset
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      woke_ff <= woke_in;
      if (ctl.load_result) begin
         rsp_ff.out_handle      <= (kind_ff == dfpq_pkg::KIND_NONE) ? '0 : slot_rd;
         rsp_ff.out_kind        <= kind_ff;
         rsp_ff.became_nonempty <= woke_ff;
         rsp_ff.length          <= occ_ff;
         rsp_ff.drop_total      <= drops_ff;
         rsp_ff.highwater       <= peak_ff;
      end
   end

   // head read and tail write share the accept cycle; read sees old data
   dfpq_ram #(
      .WIDTH (dfpq_pkg::HANDLE_W),
      .DEPTH (MAX_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ctl.accept_item && is_push),
      .wr_addr (tail_ff),
      .wr_data (req_data.packet_handle),
      .rd_en   (ctl.accept_item),
      .rd_addr (head_ff),
      .rd_data (slot_rd)
   );

   assign rsp_data     = rsp_ff;
   assign cfg_capacity = cap_ff;

endmodule

// ===== rtl/core/drop_front_packet_queue.sv =====
// Top level of the drop-front packet queue.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    cmd, packet_handle
//   rsp      out        rsp_valid/stall    handle, kind, flags, length, counters
//   csr      in         APB write/read     capacity at byte address 0
//
// For each item, the accept cycle issues the head read of the slot RAM, and
// its registered read data is loaded into the result register once free.
// A new item is taken while the previous result still waits in that register.
// Reset is synchronous: pointers, length and counters clear, capacity goes to
// min(1024, MAX_DEPTH); slot contents are not cleared. A stalled result holds
// the result register and, once the next item is accepted, holds off input.
module drop_front_packet_queue #(
   parameter int MAX_DEPTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  dfpq_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output dfpq_pkg::rsp_type            rsp_data,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [2:0]                   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   dfpq_pkg::ctl_cmd_type            ctl;
   logic                             cfg_wr_en;
   logic [dfpq_pkg::LEN_W-1:0]       cfg_capacity;

   assign csr_pready = 1'b1;
   assign cfg_wr_en  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == dfpq_pkg::CSR_CAPACITY);

   // register read
   always_comb begin
      if (csr_paddr[2] == dfpq_pkg::CSR_CAPACITY) begin
         csr_prdata = {{(32 - dfpq_pkg::LEN_W){1'b0}}, cfg_capacity};
      end else begin
         csr_prdata = '0;
      end
   end

   dfpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   dfpq_datapath #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .req_data     (req_data),
      .rsp_data     (rsp_data),
      .cfg_wr_en    (cfg_wr_en),
      .cfg_wdata    (csr_pwdata[dfpq_pkg::LEN_W-1:0]),
      .cfg_capacity (cfg_capacity)
   );

   // one item in flight: the beat after an accept is always held off
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      ctl.accept_item |=> req_stall)
      else $error("input accepted while an item is in flight");

   // nothing returned means a zero handle
   a_empty_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.out_kind == dfpq_pkg::KIND_NONE)) |-> (rsp_data.out_handle == '0))
      else $error("nonzero handle with no handle returned");

   // length never exceeds the high-water mark
   a_highwater: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.length <= rsp_data.highwater))
      else $error("length above high-water mark");

   // wake flag only on a push that left one handle
   a_wake: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.became_nonempty)
         |-> ((rsp_data.length == dfpq_pkg::LEN_W'(1))
              && (rsp_data.out_kind != dfpq_pkg::KIND_POPPED)))
      else $error("wake flag with wrong length or on a pop");

endmodule

// ===== bench/tb_drop_front_packet_queue.sv =====
// Self-checking testbench for the drop-front packet queue.
module tb_drop_front_packet_queue;

   localparam int QDEPTH        = 1024;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 64;
   localparam logic [2:0] CAP_ADDR    = {dfpq_pkg::CSR_CAPACITY, 2'b00};
   localparam logic [2:0] UNUSED_ADDR = 3'd4;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   dfpq_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   dfpq_pkg::rsp_type rsp_data;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [2:0]        csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   // shadow of the queue contents and status
   logic [dfpq_pkg::HANDLE_W-1:0] held_handles[$];
   dfpq_pkg::rsp_type             pending_results[$];
   int                            queue_capacity;
   logic [31:0]                   drop_count;
   int                            peak_len;

   int fail_count;
   int burst_left;
   bit sender_gaps_on;
   bit stall_on;
   bit hold_request;
   int hold_left;
   int stall_run;
   int free_run;
   int quiet_cycles;

   drop_front_packet_queue #(.MAX_DEPTH(QDEPTH)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // queue behavior for one accepted beat; queues the expected result
   task automatic predict_queue_op(input logic cmd,
                                   input logic [dfpq_pkg::HANDLE_W-1:0] handle);
      dfpq_pkg::rsp_type r;
      r = '0;
      if (cmd == dfpq_pkg::CMD_PUSH) begin
         if (held_handles.size() >= queue_capacity) begin
            r.out_handle = held_handles.pop_front();
            r.out_kind   = dfpq_pkg::KIND_DROPPED;
            if (drop_count != 32'hFFFF_FFFF) drop_count = drop_count + 32'd1;
         end
         held_handles.push_back(handle);
         if (held_handles.size() > peak_len) peak_len = held_handles.size();
         r.became_nonempty = (held_handles.size() == 1);
      end else if (held_handles.size() != 0) begin
         r.out_handle = held_handles.pop_front();
         r.out_kind   = dfpq_pkg::KIND_POPPED;
      end
      r.length     = dfpq_pkg::LEN_W'(held_handles.size());
      r.drop_total = drop_count;
      r.highwater  = dfpq_pkg::LEN_W'(peak_len);
      pending_results.push_back(r);
   endtask

   // send one beat, with burst/gap idling when enabled
   task automatic send_beat(input logic cmd, input logic [dfpq_pkg::HANDLE_W-1:0] handle);
      int gap;
      if (burst_left == 0) begin
         gap = sender_gaps_on ? $urandom_range(0, 5) : 0;
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= '{cmd: cmd, packet_handle: handle};
      do @(posedge clock); while (req_stall);
      predict_queue_op(cmd, handle);
   endtask

   // stop offering beats and wait for every outstanding result
   task automatic settle();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
      logic [dfpq_pkg::LEN_W-1:0] v;
      settle();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock) csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // capacity only changes while empty; zero means one, clamp at depth
      v = value[dfpq_pkg::LEN_W-1:0];
      if (addr[2] == dfpq_pkg::CSR_CAPACITY && held_handles.size() == 0) begin
         if (v == 0) queue_capacity = 1;
         else if (v > QDEPTH) queue_capacity = QDEPTH;
         else queue_capacity = int'(v);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic drain_queue();
      while (held_handles.size() != 0)
         send_beat(dfpq_pkg::CMD_POP, dfpq_pkg::HANDLE_W'($urandom));
   endtask

   // empty pops, handle extremes, wake flag
   task automatic test_basic_ops();
      send_beat(dfpq_pkg::CMD_POP, 16'hFFFF);
      send_beat(dfpq_pkg::CMD_PUSH, 16'h0000);
      send_beat(dfpq_pkg::CMD_PUSH, 16'hFFFF);
      send_beat(dfpq_pkg::CMD_PUSH, 16'h5A5A);
      send_beat(dfpq_pkg::CMD_POP, 16'h0000);
      send_beat(dfpq_pkg::CMD_POP, 16'h1234);
      send_beat(dfpq_pkg::CMD_POP, 16'h0000);
      send_beat(dfpq_pkg::CMD_POP, 16'h0000);
      send_beat(dfpq_pkg::CMD_PUSH, 16'h8001);
      send_beat(dfpq_pkg::CMD_POP, 16'hFFFF);
   endtask

   // capacity zero, masked upper bits, ignored writes, clamping
   task automatic test_capacity_limits();
      write_reg(CAP_ADDR, 32'h0000_0800);
      send_beat(dfpq_pkg::CMD_PUSH, 16'hAAAA);
      send_beat(dfpq_pkg::CMD_PUSH, 16'h5555);
      send_beat(dfpq_pkg::CMD_PUSH, 16'hFFFF);
      send_beat(dfpq_pkg::CMD_POP, 16'h0000);
      send_beat(dfpq_pkg::CMD_POP, 16'h0000);
      write_reg(CAP_ADDR, 32'hFFFF_F802);
      send_beat(dfpq_pkg::CMD_PUSH, 16'h0001);
      send_beat(dfpq_pkg::CMD_PUSH, 16'h0002);
      send_beat(dfpq_pkg::CMD_PUSH, 16'h0003);
      // not empty: this write must not take
      write_reg(CAP_ADDR, 32'd1024);
      send_beat(dfpq_pkg::CMD_PUSH, 16'h0004);
      send_beat(dfpq_pkg::CMD_PUSH, 16'h0005);
      drain_queue();
      // unmapped address: capacity stays at two
      write_reg(UNUSED_ADDR, 32'd5);
      send_beat(dfpq_pkg::CMD_PUSH, 16'h00F0);
      send_beat(dfpq_pkg::CMD_PUSH, 16'h0F00);
      send_beat(dfpq_pkg::CMD_PUSH, 16'hF000);
      drain_queue();
      write_reg(CAP_ADDR, 32'd2047);
      write_reg(CAP_ADDR, 32'd1025);
   endtask

   // receiver holds off long enough to back up the input side
   task automatic test_backpressure();
      write_reg(CAP_ADDR, 32'd4);
      hold_request = 1'b1;
      repeat (24)
         send_beat($urandom_range(0, 3) == 0 ? dfpq_pkg::CMD_POP : dfpq_pkg::CMD_PUSH,
                   dfpq_pkg::HANDLE_W'($urandom));
      settle();
      drain_queue();
   endtask

   // random phases at small capacities with varying push bias and idling
   task automatic test_random_mix();
      int cap;
      int push_pct;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: cap = $urandom_range(1, 3);
            1: cap = $urandom_range(4, 16);
            2: cap = $urandom_range(17, 64);
            default: cap = $urandom_range(1, 8);
         endcase
         drain_queue();
         write_reg(CAP_ADDR, 32'(cap) | ($urandom & 32'hFFFF_F800));
         sender_gaps_on = (phase % 3 != 0);
         stall_on       = (phase % 4 != 1);
         push_pct       = $urandom_range(30, 80);
         repeat (40)
            send_beat($urandom_range(0, 99) < push_pct ? dfpq_pkg::CMD_PUSH
                                                       : dfpq_pkg::CMD_POP,
                      dfpq_pkg::HANDLE_W'($urandom));
      end
      sender_gaps_on = 1'b1;
      stall_on       = 1'b1;
      drain_queue();
   endtask

   // full depth: length and high-water reach 1024, then drops at depth
   task automatic test_full_depth();
      write_reg(CAP_ADDR, 32'd1024);
      repeat (QDEPTH + 3) send_beat(dfpq_pkg::CMD_PUSH, dfpq_pkg::HANDLE_W'($urandom));
      repeat (12)
         send_beat($urandom_range(0, 1) ? dfpq_pkg::CMD_PUSH : dfpq_pkg::CMD_POP,
                   dfpq_pkg::HANDLE_W'($urandom));
   endtask

   // receiver stall pattern, with an occasional long hold
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!stall_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run--;
      end else if (free_run > 0) begin
         rsp_stall <= 1'b0;
         free_run--;
      end else begin
         stall_run = $urandom_range(0, 5);
         free_run  = $urandom_range(1, 9);
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      dfpq_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no expectation: %h", rsp_data);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("out_handle", 32'(want.out_handle), 32'(rsp_data.out_handle));
            check_field("out_kind", 32'(want.out_kind), 32'(rsp_data.out_kind));
            check_field("became_nonempty", 32'(want.became_nonempty),
                        32'(rsp_data.became_nonempty));
            check_field("length", 32'(want.length), 32'(rsp_data.length));
            check_field("drop_total", want.drop_total, rsp_data.drop_total);
            check_field("highwater", 32'(want.highwater), 32'(rsp_data.highwater));
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      queue_capacity = QDEPTH;
      drop_count     = '0;
      peak_len       = 0;
      fail_count     = 0;
      burst_left     = 0;
      sender_gaps_on = 1'b1;
      stall_on       = 1'b1;
      hold_request   = 1'b0;
      hold_left      = 0;
      stall_run      = 0;
      free_run       = 0;
      quiet_cycles   = 0;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_basic_ops();
      test_capacity_limits();
      test_backpressure();
      test_random_mix();
      test_full_depth();

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== drop_front_packet_queue.f =====
rtl/core/dfpq_pkg.sv
rtl/core/dfpq_ram.sv
rtl/core/dfpq_ctrl.sv
rtl/core/dfpq_datapath.sv
rtl/core/drop_front_packet_queue.sv
bench/tb_drop_front_packet_queue.sv
